>>> rtl/core/bhfs_pkg.sv
package bhfs_pkg;

  localparam int BUF_DEPTH  = 256;
  localparam int DROP_COUNT = 14;

  localparam int ADDR_W     = $clog2(BUF_DEPTH);
  localparam int PTR_W      = $clog2(BUF_DEPTH) + 1;
  localparam int DROP_IDX_W = (DROP_COUNT > 1) ? $clog2(DROP_COUNT) : 1;

  localparam logic [4:0] TAP_MAX = 5'd31;

  localparam logic [1:0] TAG_S0 = 2'b00;
  localparam logic [1:0] TAG_S1 = 2'b01;
  localparam logic [1:0] TAG_S2 = 2'b10;
  localparam logic [1:0] TAG_S3 = 2'b11;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_LOAD_A = 2'd1,
    OP_LOAD_B = 2'd2,
    OP_STATUS = 2'd3
  } op_e;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  typedef struct packed {
    logic in_range;
    logic credit_ok;
    logic space_flag;
  } drop_status_t;

endpackage

>>> rtl/core/bus_head_frame_scheduler.sv
// Transmit scheduler for the head of a multidrop bus.
// The input channel carries one word per operation: a tick, a byte load into
// channel A or channel B, or a status update for one drop. The output channel
// returns one word per operation: a packed 32-bit frame with frame_valid set
// for a tick, or the accepted flag for a load or status update.
// Each channel keeps its packet in a single-port byte memory with a registered
// read, and a tick reads up to two bytes from it one after the other.
// A load or status update finishes in the idle state, as does a tick that
// sends no stored bytes; a tick that sends stored bytes reads the first in
// ST_RD0 and a second, if any, in ST_RD1. The block works on one word at a
// time and takes the next input word once the current result has moved into
// the output register.
// When the receiver stalls, the result waits in the output register, and a
// second finished result waits in a holding register until the first is
// taken; no result is ever dropped.
// Reset clears the channel lengths and pointers, the tap index, the spare
// channel bit, the word bytes and the drop status table. The packet memories
// are not cleared; only bytes of a committed packet are ever sent.
module bus_head_frame_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  input  logic [4:0]  drop_i,
  input  logic [7:0]  credit_i,
  input  logic        receive_busy_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] frame_o,
  output logic        frame_valid_o,
  output logic        accepted_o
);

  localparam int PW = bhfs_pkg::PTR_W;
  localparam int AW = bhfs_pkg::ADDR_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD0  = 4'b0010,
    ST_RD1  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [4:0]    tap_q;
  logic [PW-1:0] len_a_q, rp_a_q, fill_a_q;
  logic [PW-1:0] len_b_q, rp_b_q, fill_b_q;
  logic          spare_q;
  logic [7:0]    wb0_q, wb1_q, w0_d, w1_d;
  logic [4:0]    hdr_drop_q;
  logic          hdr_flag_q;

  logic [1:0]    cnt_q;
  logic          sel_b_q;
  logic [7:0]    hdr_q, hdr_d, hdr_cur;
  logic [PW-1:0] rd_pos_q, rd_pos_nx, rd_pos;

  logic [31:0]   res_frame_q;
  logic          res_valid_q, res_acc_q;
  logic          out_valid_q, out_fv_q, out_acc_q;
  logic [31:0]   out_frame_q;

  bhfs_pkg::mem_req_t     req_a, req_b;
  logic [7:0]             rdata_a, rdata_b, rd_byte;
  bhfs_pkg::drop_status_t st;
  logic [4:0]             tbl_addr;

  logic          fire, tick_fire, load_a_fire, load_b_fire, status_fire;
  logic          a_busy, b_busy, a_ok, b_ok, b_first;
  logic [PW-1:0] pos_b, fill_a_nx, pos_b_nx;
  logic [1:0]    n_a, n_b, n_sel;
  logic          out_free;
  logic          fin, fin_valid, fin_acc;
  logic [31:0]   packed_frame, fin_frame;

  function automatic logic [1:0] calc_count(input logic [PW-1:0] len,
                                            input logic [PW-1:0] rp);
    logic [PW-1:0] rem;
    rem = len - rp;
    if (len <= rp) begin
      return 2'd0;
    end else if (rem >= PW'(2)) begin
      return 2'd2;
    end
    return rem[1:0];
  endfunction

  assign in_ready_o  = state_q == ST_IDLE;
  assign fire        = in_valid_i && in_ready_o;
  assign tick_fire   = fire && (operation_i == bhfs_pkg::OP_TICK);
  assign load_a_fire = fire && (operation_i == bhfs_pkg::OP_LOAD_A);
  assign load_b_fire = fire && (operation_i == bhfs_pkg::OP_LOAD_B);
  assign status_fire = fire && (operation_i == bhfs_pkg::OP_STATUS);
  assign out_free    = !out_valid_q || out_ready_i;

  assign a_busy    = len_a_q != '0;
  assign b_busy    = len_b_q != '0;
  assign a_ok      = !a_busy && (fill_a_q < PW'(bhfs_pkg::BUF_DEPTH));
  assign b_first   = fill_b_q == '0;
  assign pos_b     = b_first ? PW'(2) : fill_b_q;
  assign b_ok      = !b_busy && (!b_first || st.credit_ok) &&
                     (pos_b < PW'(bhfs_pkg::BUF_DEPTH));
  assign fill_a_nx = fill_a_q + 1'b1;
  assign pos_b_nx  = pos_b + 1'b1;

  assign n_a   = calc_count(len_a_q, rp_a_q);
  assign n_b   = calc_count(len_b_q, rp_b_q);
  assign n_sel = a_busy ? n_a : n_b;
  assign hdr_d = {a_busy ? n_a : (b_busy ? n_b : 2'd0),
                  a_busy ? 1'b0 : (b_busy ? 1'b1 : !spare_q),
                  tap_q};

  assign tbl_addr  = (operation_i == bhfs_pkg::OP_TICK) ? tap_q : drop_i;
  assign rd_pos_nx = rd_pos_q + 1'b1;
  assign rd_pos    = (state_q == ST_RD1) ? rd_pos_nx : rd_pos_q;

  always_comb begin
    rd_byte = rdata_a;
    if (sel_b_q) begin
      if (rd_pos == '0) begin
        rd_byte = {3'b000, hdr_drop_q};
      end else if (rd_pos == PW'(1)) begin
        rd_byte = {7'd0, hdr_flag_q};
      end else begin
        rd_byte = rdata_b;
      end
    end
  end

  bhfs_drop_table u_drop_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (status_fire),
    .addr_i  (tbl_addr),
    .credit_i(credit_i),
    .busy_i  (receive_busy_i),
    .status_o(st)
  );

  always_comb begin
    req_a = '0;
    req_b = '0;
    if (load_a_fire && a_ok) begin
      req_a.we    = 1'b1;
      req_a.addr  = fill_a_q[AW-1:0];
      req_a.wdata = data_byte_i;
    end
    if (load_b_fire && b_ok) begin
      req_b.we    = 1'b1;
      req_b.addr  = pos_b[AW-1:0];
      req_b.wdata = data_byte_i;
    end
    if (tick_fire && a_busy) begin
      req_a.re   = 1'b1;
      req_a.addr = rp_a_q[AW-1:0];
    end else if (tick_fire && b_busy) begin
      req_b.re   = 1'b1;
      req_b.addr = rp_b_q[AW-1:0];
    end
    if (state_q == ST_RD0) begin
      if (sel_b_q) begin
        req_b.re   = 1'b1;
        req_b.addr = rd_pos_nx[AW-1:0];
      end else begin
        req_a.re   = 1'b1;
        req_a.addr = rd_pos_nx[AW-1:0];
      end
    end
  end

  bhfs_store u_store_a (
    .clk_i  (clk_i),
    .req_i  (req_a),
    .rdata_o(rdata_a)
  );

  bhfs_store u_store_b (
    .clk_i  (clk_i),
    .req_i  (req_b),
    .rdata_o(rdata_b)
  );

  assign hdr_cur = (state_q == ST_IDLE) ? hdr_d : hdr_q;

  bhfs_frame_pack u_pack (
    .hdr_i  (hdr_cur),
    .w0_i   (w0_d),
    .w1_i   (w1_d),
    .frame_o(packed_frame)
  );

  always_comb begin
    w0_d      = wb0_q;
    w1_d      = wb1_q;
    fin       = 1'b0;
    fin_valid = 1'b0;
    fin_acc   = 1'b0;
    state_d   = state_q;
    case (state_q)
      ST_IDLE: begin
        if (tick_fire) begin
          fin_valid = 1'b1;
          if (!a_busy && !b_busy) begin
            w0_d = {7'd0, st.space_flag};
            fin  = 1'b1;
          end else if (n_sel == 2'd0) begin
            fin = 1'b1;
          end else begin
            state_d = ST_RD0;
          end
        end else if (fire) begin
          fin = 1'b1;
          case (operation_i)
            bhfs_pkg::OP_LOAD_A: fin_acc = a_ok;
            bhfs_pkg::OP_LOAD_B: fin_acc = b_ok;
            default:             fin_acc = st.in_range;
          endcase
        end
      end
      ST_RD0: begin
        fin_valid = 1'b1;
        w0_d      = rd_byte;
        if (cnt_q == 2'd2) begin
          state_d = ST_RD1;
        end else begin
          fin = 1'b1;
        end
      end
      ST_RD1: begin
        fin_valid = 1'b1;
        w1_d      = rd_byte;
        fin       = 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (fin) begin
      state_d = out_free ? ST_IDLE : ST_DONE;
    end
  end

  assign fin_frame = fin_valid ? packed_frame : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      tap_q      <= '0;
      len_a_q    <= '0;
      rp_a_q     <= '0;
      fill_a_q   <= '0;
      len_b_q    <= '0;
      rp_b_q     <= '0;
      fill_b_q   <= '0;
      spare_q    <= 1'b0;
      wb0_q      <= '0;
      wb1_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wb0_q   <= w0_d;
      wb1_q   <= w1_d;

      if (load_a_fire && a_ok) begin
        if (last_i) begin
          len_a_q  <= fill_a_nx;
          rp_a_q   <= '0;
          fill_a_q <= '0;
        end else begin
          fill_a_q <= fill_a_nx;
        end
      end

      if (load_b_fire && b_ok) begin
        if (last_i) begin
          len_b_q  <= pos_b_nx;
          rp_b_q   <= '0;
          fill_b_q <= '0;
        end else begin
          fill_b_q <= pos_b_nx;
        end
      end

      if (tick_fire) begin
        tap_q <= (tap_q >= bhfs_pkg::TAP_MAX) ? 5'd0 : tap_q + 5'd1;
        if (a_busy) begin
          if (n_a < 2'd2) begin
            len_a_q <= '0;
            rp_a_q  <= '0;
          end else begin
            rp_a_q <= rp_a_q + PW'(2);
          end
        end else if (b_busy) begin
          if (n_b < 2'd2) begin
            len_b_q <= '0;
            rp_b_q  <= '0;
          end else begin
            rp_b_q <= rp_b_q + PW'(2);
          end
        end else begin
          spare_q <= !spare_q;
        end
      end

      if ((fin || state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_b_fire && b_ok && b_first) begin
      hdr_drop_q <= drop_i;
      hdr_flag_q <= st.space_flag;
    end
    if (tick_fire) begin
      hdr_q    <= hdr_d;
      cnt_q    <= n_sel;
      sel_b_q  <= !a_busy;
      rd_pos_q <= a_busy ? rp_a_q : rp_b_q;
    end
    if (fin && !out_free) begin
      res_frame_q <= fin_frame;
      res_valid_q <= fin_valid;
      res_acc_q   <= fin_acc;
    end
    if (fin && out_free) begin
      out_frame_q <= fin_frame;
      out_fv_q    <= fin_valid;
      out_acc_q   <= fin_acc;
    end else if (state_q == ST_DONE && out_free) begin
      out_frame_q <= res_frame_q;
      out_fv_q    <= res_valid_q;
      out_acc_q   <= res_acc_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign frame_o       = out_frame_q;
  assign frame_valid_o = out_fv_q;
  assign accepted_o    = out_acc_q;

`ifndef SYNTHESIS
  a_mem_a_port : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_a.we && req_a.re))
    else $error("channel A memory written and read in one cycle");

  a_mem_b_port : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_b.we && req_b.re))
    else $error("channel B memory written and read in one cycle");

  a_rd1_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD1) |-> $past(state_q == ST_RD0))
    else $error("second byte read without first byte read");

  a_commit_clears_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_a_q == '0 || fill_a_q == '0) && (len_b_q == '0 || fill_b_q == '0))
    else $error("fill position nonzero while a packet is committed");
`endif

endmodule

>>> rtl/core/bhfs_store.sv
module bhfs_store (
  input  logic              clk_i,
  input  bhfs_pkg::mem_req_t req_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem [bhfs_pkg::BUF_DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_o <= mem[req_i.addr];
    end
  end

endmodule

>>> rtl/core/bhfs_drop_table.sv
module bhfs_drop_table (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    we_i,
  input  logic [4:0]              addr_i,
  input  logic [7:0]              credit_i,
  input  logic                    busy_i,
  output bhfs_pkg::drop_status_t  status_o
);

  logic [7:0] credit_q [bhfs_pkg::DROP_COUNT];
  logic       busy_q   [bhfs_pkg::DROP_COUNT];
  logic [bhfs_pkg::DROP_IDX_W-1:0] idx;
  logic       in_range;

  assign in_range = {1'b0, addr_i} < 6'(bhfs_pkg::DROP_COUNT);
  assign idx      = bhfs_pkg::DROP_IDX_W'(addr_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bhfs_pkg::DROP_COUNT; i++) begin
        credit_q[i] <= 8'd0;
        busy_q[i]   <= 1'b0;
      end
    end else if (we_i && in_range) begin
      credit_q[idx] <= credit_i;
      busy_q[idx]   <= busy_i;
    end
  end

  always_comb begin
    status_o.in_range   = in_range;
    status_o.credit_ok  = 1'b0;
    status_o.space_flag = 1'b0;
    if (in_range) begin
      status_o.credit_ok  = credit_q[idx] != 8'd0;
      status_o.space_flag = !busy_q[idx];
    end
  end

endmodule

>>> rtl/core/bhfs_frame_pack.sv
module bhfs_frame_pack (
  input  logic [7:0]  hdr_i,
  input  logic [7:0]  w0_i,
  input  logic [7:0]  w1_i,
  output logic [31:0] frame_o
);

  assign frame_o = {bhfs_pkg::TAG_S0, hdr_i[7:2],
                    bhfs_pkg::TAG_S1, hdr_i[1:0], w0_i[7:4],
                    bhfs_pkg::TAG_S2, w0_i[3:0], w1_i[7:6],
                    bhfs_pkg::TAG_S3, w1_i[5:0]};

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int CH_A = 0;
  localparam int CH_B = 1;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic [31:0] frame;
    logic        frame_valid;
    logic        accepted;
  } reply_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  bhfs_pkg::op_e     operation_i = bhfs_pkg::OP_TICK;
  logic [7:0]        data_byte_i = '0;
  logic              last_i = 1'b0;
  logic [4:0]        drop_i = '0;
  logic [7:0]        credit_i = '0;
  logic              receive_busy_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [31:0]       frame_o;
  logic              frame_valid_o;
  logic              accepted_o;

  bus_head_frame_scheduler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .data_byte_i    (data_byte_i),
    .last_i         (last_i),
    .drop_i         (drop_i),
    .credit_i       (credit_i),
    .receive_busy_i (receive_busy_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_o        (frame_o),
    .frame_valid_o  (frame_valid_o),
    .accepted_o     (accepted_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Transmit-side state as the scheduler should hold it.
  logic [4:0]                 tap_next = '0;
  logic [7:0]                 pkt_mem [2][bhfs_pkg::BUF_DEPTH];
  logic [bhfs_pkg::PTR_W-1:0] pkt_len [2] = '{default: '0};
  logic [bhfs_pkg::PTR_W-1:0] pkt_rd [2] = '{default: '0};
  logic [bhfs_pkg::PTR_W-1:0] pkt_fill [2] = '{default: '0};
  logic                       spare_ch = 1'b0;
  logic [7:0]                 word_q [2] = '{default: '0};
  logic [7:0]                 drop_credit_tab [bhfs_pkg::DROP_COUNT] = '{default: '0};
  logic                       drop_busy_tab [bhfs_pkg::DROP_COUNT] = '{default: 1'b0};

  reply_t      replies_due [$];
  reply_t      oldest_reply;
  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_stall = 0;
  int unsigned rx_hold = 0;
  bit          quiet = 1'b0;

  function automatic logic [7:0] space_flag_of(input logic [4:0] drop);
    if (drop < bhfs_pkg::DROP_COUNT && !drop_busy_tab[drop]) return 8'd1;
    return 8'd0;
  endfunction

  function automatic logic [1:0] take_bytes(input int ch);
    logic [1:0] n;
    n = (pkt_len[ch] - pkt_rd[ch] >= 2) ? 2'd2 : 2'(pkt_len[ch] - pkt_rd[ch]);
    for (int i = 0; i < n; i++) begin
      word_q[i] = pkt_mem[ch][pkt_rd[ch][bhfs_pkg::ADDR_W-1:0]];
      pkt_rd[ch] = pkt_rd[ch] + 1'b1;
    end
    if (n < 2) begin
      pkt_len[ch] = '0;
      pkt_rd[ch] = '0;
    end
    return n;
  endfunction

  function automatic logic load_byte(input int ch, input logic [7:0] data, input logic is_last);
    if (pkt_len[ch] != 0 || pkt_fill[ch] >= bhfs_pkg::BUF_DEPTH) return 1'b0;
    pkt_mem[ch][pkt_fill[ch][bhfs_pkg::ADDR_W-1:0]] = data;
    pkt_fill[ch] = pkt_fill[ch] + 1'b1;
    if (is_last) begin
      pkt_len[ch] = pkt_fill[ch];
      pkt_rd[ch] = '0;
      pkt_fill[ch] = '0;
    end
    return 1'b1;
  endfunction

  function automatic reply_t predict_reply(input bhfs_pkg::op_e op, input logic [7:0] data,
                                           input logic is_last, input logic [4:0] drop,
                                           input logic [7:0] credit, input logic busy);
    reply_t     r;
    logic [4:0] tapped;
    logic [7:0] hdr;
    r = '0;
    case (op)
      bhfs_pkg::OP_TICK: begin
        tapped = tap_next;
        hdr = {3'b000, tapped};
        tap_next = (tapped == bhfs_pkg::TAP_MAX) ? 5'd0 : tapped + 5'd1;
        if (pkt_len[CH_A] != 0) begin
          hdr[7:6] = take_bytes(CH_A);
        end else if (pkt_len[CH_B] != 0) begin
          hdr[7:6] = take_bytes(CH_B);
          hdr[5] = 1'b1;
        end else begin
          word_q[0] = space_flag_of(tapped);
          hdr[5] = ~spare_ch;
          spare_ch = ~spare_ch;
        end
        r.frame = {bhfs_pkg::TAG_S0, hdr[7:2],
                   bhfs_pkg::TAG_S1, hdr[1:0], word_q[0][7:4],
                   bhfs_pkg::TAG_S2, word_q[0][3:0], word_q[1][7:6],
                   bhfs_pkg::TAG_S3, word_q[1][5:0]};
        r.frame_valid = 1'b1;
      end
      bhfs_pkg::OP_LOAD_A: begin
        r.accepted = load_byte(CH_A, data, is_last);
      end
      bhfs_pkg::OP_LOAD_B: begin
        if (pkt_len[CH_B] == 0 && pkt_fill[CH_B] == 0) begin
          if (drop < bhfs_pkg::DROP_COUNT && drop_credit_tab[drop] != 0) begin
            pkt_mem[CH_B][0] = {3'b000, drop};
            pkt_mem[CH_B][1] = space_flag_of(drop);
            pkt_fill[CH_B] = bhfs_pkg::PTR_W'(2);
            r.accepted = load_byte(CH_B, data, is_last);
          end
        end else begin
          r.accepted = load_byte(CH_B, data, is_last);
        end
      end
      default: begin
        if (drop < bhfs_pkg::DROP_COUNT) begin
          drop_credit_tab[drop] = credit;
          drop_busy_tab[drop] = busy;
          r.accepted = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_word(input bhfs_pkg::op_e op, input logic [7:0] data,
                           input logic is_last, input logic [4:0] drop,
                           input logic [7:0] credit, input logic busy);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    data_byte_i    <= data;
    last_i         <= is_last;
    drop_i         <= drop;
    credit_i       <= credit;
    receive_busy_i <= busy;
    replies_due.push_back(predict_reply(op, data, is_last, drop, credit, busy));
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  task automatic send_tick();
    send_word(bhfs_pkg::OP_TICK, 8'($urandom()), 1'($urandom()), 5'($urandom()),
              8'($urandom()), 1'($urandom()));
  endtask

  task automatic load_packet(input bhfs_pkg::op_e op, input int len,
                             input logic [4:0] first_drop, input bit commit,
                             input bit mix_ticks);
    for (int i = 0; i < len; i++) begin
      if (mix_ticks && $urandom_range(0, 9) == 0) send_tick();
      send_word(op, 8'($urandom()), commit && (i == len - 1),
                (i == 0) ? first_drop : 5'($urandom()), 8'($urandom()), 1'($urandom()));
    end
  endtask

  function automatic int random_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(7, 40);
    return $urandom_range(1, 6);
  endfunction

  task automatic wait_replies_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (replies_due.size() != 0);
  endtask

  task automatic test_directed();
    send_tick();
    send_word(bhfs_pkg::OP_STATUS, 8'h00, 1'b0, 5'd0, 8'd0, 1'b1);
    send_word(bhfs_pkg::OP_STATUS, 8'hFF, 1'b1, 5'd13, 8'd255, 1'b0);
    send_word(bhfs_pkg::OP_STATUS, 8'h00, 1'b0, 5'd14, 8'd255, 1'b0);
    send_word(bhfs_pkg::OP_STATUS, 8'hFF, 1'b1, 5'd31, 8'd1, 1'b1);
    send_word(bhfs_pkg::OP_LOAD_B, 8'h11, 1'b1, 5'd0, 8'd0, 1'b0);
    send_word(bhfs_pkg::OP_LOAD_B, 8'h22, 1'b1, 5'd20, 8'd0, 1'b0);
    send_word(bhfs_pkg::OP_LOAD_B, 8'hFF, 1'b0, 5'd13, 8'd0, 1'b0);
    send_word(bhfs_pkg::OP_LOAD_B, 8'h00, 1'b1, 5'd0, 8'd0, 1'b0);
    send_word(bhfs_pkg::OP_LOAD_B, 8'h5A, 1'b1, 5'd13, 8'd0, 1'b0);
    send_word(bhfs_pkg::OP_LOAD_A, 8'h00, 1'b0, 5'd0, 8'd0, 1'b0);
    send_word(bhfs_pkg::OP_LOAD_A, 8'hFF, 1'b0, 5'd31, 8'd0, 1'b0);
    send_word(bhfs_pkg::OP_LOAD_A, 8'hA5, 1'b1, 5'd0, 8'd0, 1'b0);
    send_word(bhfs_pkg::OP_LOAD_A, 8'h3C, 1'b1, 5'd0, 8'd0, 1'b0);
    repeat (6) send_tick();
    send_word(bhfs_pkg::OP_STATUS, 8'h00, 1'b0, 5'd0, 8'd1, 1'b0);
    send_tick();
  endtask

  task automatic test_backpressure();
    quiet = 1'b1;
    rx_hold = 80;
    for (int i = 0; i < 30; i++) begin
      case (i % 3)
        0: send_word(bhfs_pkg::OP_LOAD_A, 8'($urandom()), 1'b1, 5'($urandom()),
                     8'($urandom()), 1'($urandom()));
        1: send_word(bhfs_pkg::OP_STATUS, 8'($urandom()), 1'($urandom()),
                     5'($urandom_range(0, 13)), 8'($urandom()), 1'($urandom()));
        default: send_tick();
      endcase
    end
    quiet = 1'b0;
    wait_replies_drained();
  endtask

  task automatic test_long_packets();
    repeat (4) send_tick();
    send_word(bhfs_pkg::OP_STATUS, 8'h00, 1'b0, 5'd5, 8'd9, 1'b0);
    load_packet(bhfs_pkg::OP_LOAD_A, bhfs_pkg::BUF_DEPTH, 5'd0, 1'b1, 1'b0);
    load_packet(bhfs_pkg::OP_LOAD_B, 40, 5'd5, 1'b1, 1'b0);
    while (pkt_len[CH_A] != 0 || pkt_len[CH_B] != 0) send_tick();
    repeat (2) send_tick();
    wait_replies_drained();
  endtask

  task automatic test_random(input int unsigned n_words, input bit no_idle);
    int unsigned pick;
    int unsigned stop_at;
    quiet = no_idle;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_tick();
      end else if (pick < 45) begin
        send_word(bhfs_pkg::OP_STATUS, 8'($urandom()), 1'($urandom()),
                  5'($urandom_range(0, 15)),
                  ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom()), 1'($urandom()));
      end else if (pick < 65) begin
        load_packet(bhfs_pkg::OP_LOAD_A, random_length(), 5'($urandom()), 1'b1, 1'b1);
      end else if (pick < 85) begin
        load_packet(bhfs_pkg::OP_LOAD_B, random_length(), 5'($urandom_range(0, 15)),
                    1'b1, 1'b1);
      end else begin
        send_word(bhfs_pkg::op_e'($urandom_range(0, 3)), 8'($urandom()), 1'($urandom()),
                  5'($urandom()), 8'($urandom()), 1'($urandom()));
      end
    end
    quiet = 1'b0;
    wait_replies_drained();
  endtask

  // Filling a channel to the end of its buffer without a final byte leaves it
  // refusing loads for good, so this runs last.
  task automatic test_buffer_full();
    send_word(bhfs_pkg::OP_STATUS, 8'h00, 1'b0, 5'd7, 8'd1, 1'b1);
    while (pkt_len[CH_A] != 0 || pkt_len[CH_B] != 0) send_tick();
    while (pkt_fill[CH_A] < bhfs_pkg::BUF_DEPTH) begin
      send_word(bhfs_pkg::OP_LOAD_A, 8'($urandom()), 1'b0, 5'($urandom()), 8'd0, 1'b0);
    end
    send_word(bhfs_pkg::OP_LOAD_A, 8'hEE, 1'b1, 5'd0, 8'd0, 1'b0);
    send_word(bhfs_pkg::OP_LOAD_A, 8'h11, 1'b0, 5'd0, 8'd0, 1'b0);
    while (pkt_fill[CH_B] < bhfs_pkg::BUF_DEPTH) begin
      send_word(bhfs_pkg::OP_LOAD_B, 8'($urandom()), 1'b0, 5'd7, 8'd0, 1'b0);
    end
    send_word(bhfs_pkg::OP_LOAD_B, 8'hEE, 1'b1, 5'd7, 8'd0, 1'b0);
    send_word(bhfs_pkg::OP_LOAD_B, 8'h11, 1'b0, 5'd7, 8'd0, 1'b0);
    repeat (6) send_tick();
    wait_replies_drained();
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold != 0) begin
        rx_hold--;
        out_ready_i <= 1'b0;
      end else begin
        if (out_valid_o && out_ready_i) rx_stall = quiet ? 0 : $urandom_range(0, 3);
        if (rx_stall == 0) begin
          out_ready_i <= 1'b1;
        end else begin
          rx_stall--;
          out_ready_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (replies_due.size() == 0) begin
        $error("result with no word outstanding: frame %h", frame_o);
        errors++;
      end else begin
        oldest_reply = replies_due.pop_front();
        if (frame_o !== oldest_reply.frame) begin
          $error("frame: expected %h, got %h", oldest_reply.frame, frame_o);
          errors++;
        end
        if (frame_valid_o !== oldest_reply.frame_valid) begin
          $error("frame_valid: expected %b, got %b", oldest_reply.frame_valid, frame_valid_o);
          errors++;
        end
        if (accepted_o !== oldest_reply.accepted) begin
          $error("accepted: expected %b, got %b", oldest_reply.accepted, accepted_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    wait_replies_drained();
    test_backpressure();
    test_long_packets();
    test_random(120, 1'b0);
    test_random(40, 1'b1);
    test_random(60, 1'b0);
    test_buffer_full();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/bhfs_pkg.sv
rtl/core/bhfs_store.sv
rtl/core/bhfs_drop_table.sv
rtl/core/bhfs_frame_pack.sv
rtl/core/bus_head_frame_scheduler.sv
bench/tb_top.sv
